// File: rtl/pfss_pkg.sv
package pfss_pkg;

  localparam int TableDepthDef = 16;
  localparam int SecW = 40;
  localparam int NsW = 30;
  localparam int PreW = 11;
  localparam int WaitW = 18;
  localparam int InfoW = 36;
  localparam int ModSteps = SecW / 2;
  localparam logic [PreW-1:0] PrerollReset = 11'd200;

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  typedef enum logic [1:0] {
    ST_SCHEDULED,
    ST_QUEUE_FULL,
    ST_NONE_DUE,
    ST_FIRED
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] capcode;
    logic [1:0]  msg_type;
    logic [1:0]  speed_code;
    logic [39:0] now_sec;
    logic [29:0] now_ns;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page_capcode;
    logic [1:0]  page_type;
    logic [1:0]  page_speed;
    logic [6:0]  slot_frame;
    logic [3:0]  fire_cycle;
    logic [6:0]  fire_frame;
    logic [17:0] wait_ms;
    logic [4:0]  pending_count;
    logic [31:0] sent_total;
  } rsp_t;

  typedef struct packed {
    logic [InfoW-1:0] info;
    logic [SecW-1:0]  fire_sec;
    logic [NsW-1:0]   fire_ns;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_FL1,
    S_FL2,
    S_FL3,
    S_WAITC,
    S_DIVQ,
    S_DIVR,
    S_NSC,
    S_STORE,
    S_REMOD,
    S_LOOK,
    S_CMP,
    S_SHIFT,
    S_SHIFT_WR,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    load_req;
    logic    mod_start;
    logic    mod_src_fire;
    logic    calc_wait;
    logic    div_q;
    logic    div_r;
    logic    calc_ns;
    logic    store;
    logic    idx_clear;
    logic    idx_inc;
    logic    rd_next;
    logic    capture_hit;
    logic    shift_wr;
    logic    pop;
    logic    load_res;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic opcode;
    logic full;
    logic empty;
    logic mod_done;
    logic hit;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/pfss_ctrl.sv
module pfss_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pfss_pkg::sts_t sts,
  output pfss_pkg::cmd_t cmd
);
  import pfss_pkg::*;

  state_t  state, state_next;
  logic    phase, phase_next;
  status_t res_status, res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= 1'b0;
      res_status <= ST_NONE_DUE;
    end else begin
      state <= state_next;
      phase <= phase_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    res_status_next = res_status;
    cmd = '0;
    cmd.res_status = res_status;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.opcode == OP_SCHEDULE) begin
          if (sts.full) begin
            res_status_next = ST_QUEUE_FULL;
            state_next = S_FIN;
          end else begin
            cmd.mod_start = 1'b1;
            phase_next = 1'b0;
            state_next = S_MOD;
          end
        end else if (sts.empty) begin
          res_status_next = ST_NONE_DUE;
          state_next = S_FIN;
        end else begin
          cmd.idx_clear = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_next = S_FL1;
        end
      end
      S_FL1: state_next = S_FL2;
      S_FL2: state_next = S_FL3;
      S_FL3: state_next = phase ? S_FIN : S_WAITC;
      S_WAITC: begin
        cmd.calc_wait = 1'b1;
        state_next = S_DIVQ;
      end
      S_DIVQ: begin
        cmd.div_q = 1'b1;
        state_next = S_DIVR;
      end
      S_DIVR: begin
        cmd.div_r = 1'b1;
        state_next = S_NSC;
      end
      S_NSC: begin
        cmd.calc_ns = 1'b1;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        res_status_next = ST_SCHEDULED;
        state_next = S_REMOD;
      end
      S_REMOD: begin
        cmd.mod_start = 1'b1;
        cmd.mod_src_fire = 1'b1;
        phase_next = 1'b1;
        state_next = S_MOD;
      end
      S_LOOK: state_next = S_CMP;
      S_CMP: begin
        if (sts.hit) begin
          cmd.capture_hit = 1'b1;
          state_next = S_SHIFT;
        end else if (sts.last) begin
          res_status_next = ST_NONE_DUE;
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_SHIFT: begin
        if (sts.last) begin
          cmd.pop = 1'b1;
          res_status_next = ST_FIRED;
          state_next = S_REMOD;
        end else begin
          cmd.rd_next = 1'b1;
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_SHIFT;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_res = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/pfss_dp.sv
module pfss_dp #(
  parameter int TABLE_DEPTH = pfss_pkg::TableDepthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  pfss_pkg::req_t in_data,
  input  logic           cfg_wr_en,
  input  logic [10:0]    cfg_wr_data,
  input  pfss_pkg::cmd_t cmd,
  output pfss_pkg::sts_t sts,
  input  logic           out_ready,
  output logic           out_valid,
  output pfss_pkg::rsp_t out_data
);
  import pfss_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  entry_t entries [TABLE_DEPTH];
  entry_t rdata;
  entry_t wr_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;

  req_t              req;
  logic [InfoW-1:0]  info;
  logic [PreW-1:0]   preroll;
  logic [CW-1:0]     entry_count;
  logic [31:0]       sent_count;
  logic [IW-1:0]     idx;
  logic [CW-1:0]     idx_p1;

  logic [SecW-1:0]   mod_sh;
  logic [11:0]       h;
  logic [11:0]       h_step;
  logic [13:0]       x;
  logic [4:0]        mod_cnt;
  logic              mod_busy;
  logic [1:0]        pre_sec;
  logic [SecW-1:0]   mod_src;

  logic [24:0]       q_prod;
  logic [23:0]       f_prod;
  logic [3:0]        q_reg;
  logic [7:0]        r_reg;
  logic [6:0]        frm;

  logic [8:0]        delta9;
  logic [7:0]        delta;
  logic [17:0]       slot_ms;
  logic [18:0]       wait_raw;
  logic [WaitW-1:0]  wait_reg;
  logic [36:0]       wq_prod;
  logic [7:0]        wq;
  logic [9:0]        wr;
  logic [30:0]       nsum;
  logic              carry;
  logic [SecW-1:0]   fs;
  logic [NsW-1:0]    fn;
  logic [SecW-1:0]   fs_reg;
  logic              timed;

  // Requests and the preroll register.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preroll <= PrerollReset;
    end else if (cfg_wr_en) begin
      preroll <= cfg_wr_data;
    end
  end

  // Seconds modulo one hour, two bits a cycle, most significant first.
  always_comb begin
    pre_sec = (preroll >= 11'd2000) ? 2'd2 : ((preroll >= 11'd1000) ? 2'd1 : 2'd0);
    mod_src = cmd.mod_src_fire ? (fs_reg + SecW'(pre_sec)) : req.now_sec;
    x = {h, mod_sh[SecW-1 -: 2]};
    if (x >= 14'd10800) begin
      h_step = 12'(x - 14'd10800);
    end else if (x >= 14'd7200) begin
      h_step = 12'(x - 14'd7200);
    end else if (x >= 14'd3600) begin
      h_step = 12'(x - 14'd3600);
    end else begin
      h_step = x[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_busy <= 1'b0;
      mod_cnt <= '0;
    end else if (cmd.mod_start) begin
      mod_busy <= 1'b1;
      mod_cnt <= '0;
    end else if (mod_busy) begin
      mod_cnt <= mod_cnt + 5'd1;
      if (mod_cnt == 5'(ModSteps - 1)) begin
        mod_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      mod_sh <= mod_src;
      h <= '0;
    end else if (mod_busy) begin
      mod_sh <= mod_sh << 2;
      h <= h_step;
    end
  end

  // Cycle and frame from the second within the hour.
  always_comb begin
    q_prod = 25'(h) * 25'd4370;
    f_prod = 24'({r_reg, 3'b000}) * 24'd4370;
  end

  always_ff @(posedge clk) begin
    q_reg <= q_prod[23:20];
    r_reg <= 8'(h - 12'(q_reg) * 12'd240);
    frm <= f_prod[22:16];
  end

  // Wait and fire time of a schedule request.
  always_comb begin
    delta9 = {2'b00, req.capcode[6:0]} - {2'b00, frm};
    if (delta9[8] || (delta9 == 9'd0)) begin
      delta = 8'(delta9 + 9'd128);
    end else begin
      delta = delta9[7:0];
    end
    slot_ms = 18'(delta) * 18'd1875;
    wait_raw = {1'b0, slot_ms} - 19'(preroll);
    wq_prod = 37'(wait_reg) * 37'd268436;
    carry = (nsum >= 31'd1000000000);
    fs = req.now_sec + SecW'(wq) + SecW'(carry);
    fn = carry ? 30'(nsum - 31'd1000000000) : nsum[NsW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_wait) begin
      wait_reg <= wait_raw[18] ? 18'(wait_raw + 19'd240000) : wait_raw[17:0];
    end
    if (cmd.div_q) begin
      wq <= wq_prod[35:28];
    end
    if (cmd.div_r) begin
      wr <= 10'(wait_reg - 18'(wq) * 18'd1000);
    end
    if (cmd.calc_ns) begin
      nsum <= 31'(req.now_ns) + 31'(wr) * 31'd1000000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      info <= {in_data.speed_code, in_data.msg_type, in_data.capcode};
    end else if (cmd.capture_hit) begin
      info <= rdata.info;
    end
    if (cmd.store) begin
      fs_reg <= fs;
    end else if (cmd.capture_hit) begin
      fs_reg <= rdata.fire_sec;
    end
  end

  // Table of pending pages, kept in order of arrival.
  always_comb begin
    idx_p1 = CW'(idx) + CW'(1);
    rd_addr = cmd.rd_next ? (idx + IW'(1)) : idx;
    wr_en = cmd.store || cmd.shift_wr;
    wr_addr = cmd.store ? entry_count[IW-1:0] : idx;
    wr_data = cmd.store ? entry_t'{info: info, fire_sec: fs, fire_ns: fn} : rdata;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    rdata <= entries[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      sent_count <= '0;
    end else if (cmd.store) begin
      entry_count <= entry_count + CW'(1);
    end else if (cmd.pop) begin
      entry_count <= entry_count - CW'(1);
      sent_count <= sent_count + 32'd1;
    end
  end

  always_comb begin
    timed = (req.now_sec > rdata.fire_sec) ||
            ((req.now_sec == rdata.fire_sec) && (req.now_ns >= rdata.fire_ns));
    sts.opcode = req.opcode;
    sts.full = (entry_count >= CW'(TABLE_DEPTH));
    sts.empty = (entry_count == '0);
    sts.mod_done = mod_busy && (mod_cnt == 5'(ModSteps - 1));
    sts.hit = timed;
    sts.last = (idx_p1 >= entry_count);
    sts.out_busy = out_valid && !out_ready;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      out_data.status <= cmd.res_status;
      out_data.page_capcode <= (cmd.res_status == ST_NONE_DUE) ? 32'd0 : info[31:0];
      out_data.page_type <= (cmd.res_status == ST_NONE_DUE) ? 2'd0 : info[33:32];
      out_data.page_speed <= (cmd.res_status == ST_NONE_DUE) ? 2'd0 : info[35:34];
      out_data.slot_frame <= (cmd.res_status == ST_NONE_DUE) ? 7'd0 : info[6:0];
      if ((cmd.res_status == ST_SCHEDULED) || (cmd.res_status == ST_FIRED)) begin
        out_data.fire_cycle <= q_reg;
        out_data.fire_frame <= frm;
      end else begin
        out_data.fire_cycle <= 4'd0;
        out_data.fire_frame <= 7'd0;
      end
      out_data.wait_ms <= (cmd.res_status == ST_SCHEDULED) ? wait_reg : 18'd0;
      out_data.pending_count <= 5'(entry_count);
      out_data.sent_total <= sent_count;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> (entry_count < CW'(TABLE_DEPTH)))
    else $error("store into a full table");

  a_sent_pop: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (sent_count != $past(sent_count))) |->
    (entry_count == $past(entry_count) - CW'(1)))
    else $error("sent count moved without removing an entry");

  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_res |-> !(out_valid && !out_ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

// File: rtl/paging_frame_slot_scheduler.sv
// Schedules pages onto FLEX frame slots. Each request yields exactly one result. A schedule
// request makes two passes of the serial hour-remainder unit (two bits of the seconds per
// cycle); a schedule request that finds the table full goes straight to the result. A poll
// scans the pending entries in order and reports none due when nothing is due or the table
// is empty; when an entry fires, the later entries are moved down, then a further remainder
// pass gives the fire cycle and frame. The controller is ready for the next request in the
// cycle after the result is loaded; it waits while the output register still holds a result
// not yet taken.
module paging_frame_slot_scheduler #(
  parameter int TABLE_DEPTH = pfss_pkg::TableDepthDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pfss_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pfss_pkg::rsp_t out_data,
  input  logic           cfg_wr_en,
  input  logic [10:0]    cfg_wr_data
);
  import pfss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pfss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfss_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
